/* hw/rtl/tsc_pkg.sv */
// Shared constants and types for the tonal shadow color pipeline.
`default_nettype none

package tsc_pkg;

    // Default number of fraction bits in the fixed-point datapath.
    localparam int FRAC_BITS_DEF = 16;

    // Exact division of a value below 2^17 by 255: floor(y * MUL / 2^SHIFT).
    localparam int          DIV255_SHIFT = 25;
    localparam int          DIV255_PW    = 35;
    localparam logic [17:0] DIV255_MUL   = 18'((64'd1 << DIV255_SHIFT) / 64'd255 + 64'd1);

    // Width of a stream item on either side.
    localparam int TDATA_W = 40;

    // Byte fields that ride along the pipeline next to the arithmetic.
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] amb;
    } tsc_pix_t;

endpackage : tsc_pkg

`default_nettype wire

/* hw/rtl/tonal_shadow_color_top.sv */
// Top level of the tonal shadow color pipeline: luminance, polynomials, divide, scale.
//
//  Channel   Direction  tdata fields, lowest bits first
//  s_axis    in         ambient_alpha, spot_alpha, spot_red, spot_green, spot_blue
//  m_axis    out        out_ambient_alpha, tonal_alpha, tonal_red, tonal_green, tonal_blue
//
// One item is taken every cycle while m_axis is not stalled; the pipeline holds ten
// arithmetic and output stages plus FRAC_BITS + 1 stages of the pipelined divider.
// The divider (one quotient bit per stage) sets the depth.
// Reset (aresetn low, synchronous) clears all valid bits; payload registers are not reset.
// When m_axis_tready is low with a result waiting, the whole pipeline holds in place and
// s_axis_tready falls in the same cycle.
`default_nettype none

module tonal_shadow_color_top #(
    parameter int FRAC_BITS = tsc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // ambient_alpha[7:0], spot_alpha[15:8], spot_red[23:16], spot_green[31:24],
    // spot_blue[39:32]
    input  wire logic [tsc_pkg::TDATA_W-1:0]  s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // out_ambient_alpha[7:0], tonal_alpha[15:8], tonal_red[23:16], tonal_green[31:24],
    // tonal_blue[39:32]
    output logic [tsc_pkg::TDATA_W-1:0]       m_axis_tdata
);
    import tsc_pkg::*;

    // Value width: every intermediate stays below 16.0 in fixed point.
    localparam int VW = FRAC_BITS + 4;
    localparam int PW = 2 * VW;
    localparam int TW = 2 * FRAC_BITS + 10;

    localparam logic [63:0] ONE64 = 64'd1 << FRAC_BITS;
    localparam logic [VW-1:0] ONE_V = VW'(ONE64);

    // Split of 2^F/255 and 2^(F-1)/255 into a whole multiple and a small remainder.
    localparam logic [FRAC_BITS-1:0] C0 = FRAC_BITS'(ONE64 / 64'd255);
    localparam logic [7:0]           R0 = 8'(ONE64 % 64'd255);
    localparam logic [FRAC_BITS-1:0] C1 = FRAC_BITS'((ONE64 >> 1) / 64'd255);
    localparam logic [7:0]           R1 = 8'((ONE64 >> 1) % 64'd255);

    // Polynomial coefficients, rounded half up.
    localparam logic [VW-1:0] K_A1 = VW'((64'd106667 * ONE64 + 64'd50000) / 64'd100000);
    localparam logic [VW-1:0] K_A2 = VW'((64'd266667 * ONE64 + 64'd50000) / 64'd100000);
    localparam logic [VW-1:0] K_A3 = VW'((64'd26 * ONE64 + 64'd5) / 64'd10);
    localparam logic [VW-1:0] K_L1 = VW'((64'd23466 * ONE64 + 64'd5000) / 64'd10000);
    localparam logic [VW-1:0] K_L2 = VW'((64'd4891428 * ONE64 + 64'd500000) / 64'd1000000);
    localparam logic [VW-1:0] K_L3 = VW'((64'd3544762 * ONE64 + 64'd500000) / 64'd1000000);
    localparam logic [VW-1:0] K_G  = VW'((64'd4 * ONE64 + 64'd5) / 64'd10);
    localparam logic [FRAC_BITS+8:0] K_T =
        (FRAC_BITS+9)'((64'd255999 * ONE64 + 64'd500) / 64'd1000);

    function automatic logic [VW-1:0] sat_sub(input logic [VW-1:0] x, input logic [VW-1:0] y);
        logic [VW-1:0] r;
        r = (x > y) ? (x - y) : '0;
        return r;
    endfunction

    function automatic logic [VW-1:0] fx(input logic [PW-1:0] p);
        return p[FRAC_BITS +: VW];
    endfunction

    function automatic logic [VW-1:0] clamp_one(input logic [VW-1:0] x);
        return (x > ONE_V) ? ONE_V : x;
    endfunction

    function automatic logic [PW-1:0] mul(input logic [VW-1:0] x, input logic [VW-1:0] y);
        return PW'(x) * PW'(y);
    endfunction

    logic        adv;
    logic [7:0]  vld_reg;
    tsc_pix_t    pix_in;
    tsc_pix_t    pix_reg [8];
    logic [7:0]  sa_in;

    // The pipeline moves whenever the output register is empty or being drained.
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    assign pix_in.amb   = s_axis_tdata[7:0];
    assign sa_in        = s_axis_tdata[15:8];
    assign pix_in.red   = s_axis_tdata[23:16];
    assign pix_in.green = s_axis_tdata[31:24];
    assign pix_in.blue  = s_axis_tdata[39:32];

    // Stage 1: max plus min of the channels, and the small constant products.
    logic [7:0]             mx, mn;
    logic [8:0]             s_sum;
    logic [FRAC_BITS+7:0]   c0p_next, c0p_reg;
    logic [FRAC_BITS+8:0]   c1p_next, c1p_reg;
    logic [16:0]            y0_next, y0_reg, y1_next, y1_reg;

    always_comb begin
        mx = pix_in.red;
        mn = pix_in.red;
        if (pix_in.green > mx) mx = pix_in.green;
        if (pix_in.blue > mx)  mx = pix_in.blue;
        if (pix_in.green < mn) mn = pix_in.green;
        if (pix_in.blue < mn)  mn = pix_in.blue;
    end

    assign s_sum    = 9'(mx) + 9'(mn);
    assign c0p_next = (FRAC_BITS+8)'(sa_in) * (FRAC_BITS+8)'(C0);
    assign c1p_next = (FRAC_BITS+9)'(s_sum) * (FRAC_BITS+9)'(C1);
    assign y0_next  = 17'(sa_in) * 17'(R0);
    assign y1_next  = 17'(s_sum) * 17'(R1);

    // Stage 2: divide the remainder parts by 255 through a reciprocal multiply.
    logic [DIV255_PW-1:0]   d0_next, d0_reg, d1_next, d1_reg;
    logic [FRAC_BITS+7:0]   c0p2_reg;
    logic [FRAC_BITS+8:0]   c1p2_reg;

    assign d0_next = DIV255_PW'(y0_reg) * DIV255_PW'(DIV255_MUL);
    assign d1_next = DIV255_PW'(y1_reg) * DIV255_PW'(DIV255_MUL);

    // Stage 3: alpha and luminance, and their first coefficient products.
    logic [VW-1:0] a_next, lum_next, a3_reg, lum3_reg;
    logic [PW-1:0] t1_next, t1_reg, t2_next, t2_reg, t3_next, t3_reg;

    assign a_next   = VW'(c0p2_reg) + VW'(d0_reg[DIV255_SHIFT +: 10]);
    assign lum_next = VW'(c1p2_reg) + VW'(d1_reg[DIV255_SHIFT +: 10]);
    assign t1_next  = mul(K_A1, a_next);
    assign t2_next  = mul(K_L1, lum_next);
    assign t3_next  = mul(K_G, lum_next);

    // Stage 4: inner Horner terms and the greyscale product.
    logic [VW-1:0] a4_reg, lum4_reg;
    logic [PW-1:0] pn1_next, pn1_reg, pn2_next, pn2_reg, pg_next, pg_reg;

    assign pn1_next = mul(sat_sub(K_A2, fx(t1_reg)), a3_reg);
    assign pn2_next = mul(sat_sub(K_L2, fx(t2_reg)), lum3_reg);
    assign pg_next  = mul(a3_reg, sat_sub(ONE_V, fx(t3_reg)));

    // Stage 5: outer Horner terms and the clamped greyscale alpha.
    logic [VW-1:0] grey_next, grey5_reg;
    logic [PW-1:0] pu1_next, pu1_reg, pu2_next, pu2_reg;

    assign grey_next = clamp_one(fx(pg_reg));
    assign pu1_next  = mul(sat_sub(K_A3, fx(pn1_reg)), a4_reg);
    assign pu2_next  = mul(sat_sub(K_L3, fx(pn2_reg)), lum4_reg);

    // Stage 6: product of the two polynomials.
    logic [VW-1:0] grey6_reg;
    logic [PW-1:0] pca_next, pca_reg;

    assign pca_next = mul(fx(pu1_reg), fx(pu2_reg));

    // Stage 7: clamped color alpha times the greyscale complement.
    logic [VW-1:0] grey7_reg;
    logic [PW-1:0] pcs_next, pcs_reg;

    assign pcs_next = mul(clamp_one(fx(pca_reg)), sat_sub(ONE_V, grey6_reg));

    // Stage 8: color scale and tonal alpha, both at most one.
    logic [FRAC_BITS:0] cs_next, cs_reg, tonal_next, tonal_reg;

    assign cs_next    = (FRAC_BITS+1)'(fx(pcs_reg));
    assign tonal_next = cs_next + (FRAC_BITS+1)'(grey7_reg);

    // Valid bits for stages 1 to 8.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[6:0], s_axis_tvalid};
        end
    end

    // Payload registers of stages 1 to 8.
    always_ff @(posedge aclk) begin
        if (adv) begin
            pix_reg[0] <= pix_in;
            for (int i = 1; i < 8; i++) begin
                pix_reg[i] <= pix_reg[i-1];
            end
            c0p_reg   <= c0p_next;
            c1p_reg   <= c1p_next;
            y0_reg    <= y0_next;
            y1_reg    <= y1_next;
            d0_reg    <= d0_next;
            d1_reg    <= d1_next;
            c0p2_reg  <= c0p_reg;
            c1p2_reg  <= c1p_reg;
            a3_reg    <= a_next;
            lum3_reg  <= lum_next;
            t1_reg    <= t1_next;
            t2_reg    <= t2_next;
            t3_reg    <= t3_next;
            a4_reg    <= a3_reg;
            lum4_reg  <= lum3_reg;
            pn1_reg   <= pn1_next;
            pn2_reg   <= pn2_next;
            pg_reg    <= pg_next;
            grey5_reg <= grey_next;
            pu1_reg   <= pu1_next;
            pu2_reg   <= pu2_next;
            grey6_reg <= grey5_reg;
            pca_reg   <= pca_next;
            grey7_reg <= grey6_reg;
            pcs_reg   <= pcs_next;
            cs_reg    <= cs_next;
            tonal_reg <= tonal_next;
        end
    end

    // Scale = cs / tonal with FRAC_BITS fraction bits.
    logic                          dv_valid;
    logic [FRAC_BITS:0]            dv_quo;
    logic [FRAC_BITS:0]            dv_tonal;
    logic [$bits(tsc_pix_t)-1:0]   dv_side;
    tsc_pix_t                      dv_pix;

    tsc_div #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    ($bits(tsc_pix_t))
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (vld_reg[7]),
        .num       (cs_reg),
        .den       (tonal_reg),
        .side_in   (pix_reg[7]),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .den_out   (dv_tonal),
        .side_out  (dv_side)
    );

    assign dv_pix = tsc_pix_t'(dv_side);

    // Stage 9: a zero tonal alpha forces a zero scale; output products.
    logic [FRAC_BITS:0]   scale;
    logic [TW-1:0]        pt_next, pt_reg;
    logic [FRAC_BITS+8:0] pr_next, pr_reg, pgr_next, pgr_reg, pb_next, pb_reg;
    logic [7:0]           amb9_reg;
    logic                 vld9_reg;

    assign scale    = (dv_tonal == '0) ? '0 : dv_quo;
    assign pt_next  = TW'(dv_tonal) * TW'(K_T);
    assign pr_next  = (FRAC_BITS+9)'(scale) * (FRAC_BITS+9)'(dv_pix.red);
    assign pgr_next = (FRAC_BITS+9)'(scale) * (FRAC_BITS+9)'(dv_pix.green);
    assign pb_next  = (FRAC_BITS+9)'(scale) * (FRAC_BITS+9)'(dv_pix.blue);

    // Stage 10: drop the fraction, saturate to a byte, and hold for the consumer.
    logic [9:0]              ta_wide;
    logic [8:0]              r_wide, g_wide, b_wide;
    logic [TDATA_W-1:0]      m_data_next, m_data_reg;
    logic                    m_valid_reg;

    assign ta_wide = pt_reg[2*FRAC_BITS +: 10];
    assign r_wide  = pr_reg[FRAC_BITS +: 9];
    assign g_wide  = pgr_reg[FRAC_BITS +: 9];
    assign b_wide  = pb_reg[FRAC_BITS +: 9];

    assign m_data_next = {
        (b_wide  > 9'd255)  ? 8'hFF : b_wide[7:0],
        (g_wide  > 9'd255)  ? 8'hFF : g_wide[7:0],
        (r_wide  > 9'd255)  ? 8'hFF : r_wide[7:0],
        (ta_wide > 10'd255) ? 8'hFF : ta_wide[7:0],
        amb9_reg
    };

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld9_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            vld9_reg    <= dv_valid;
            m_valid_reg <= vld9_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pt_reg     <= pt_next;
            pr_reg     <= pr_next;
            pgr_reg    <= pgr_next;
            pb_reg     <= pb_next;
            amb9_reg   <= dv_pix.amb;
            m_data_reg <= m_data_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

`ifndef SYNTHESIS
    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // An accepted item always occupies the first stage.
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> vld_reg[0])
        else $error("accepted item missing from first stage");

    // The color scale never exceeds the tonal alpha, so the quotient stays at or below one.
    a_cs_le_tonal: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[7] |-> (cs_reg <= tonal_reg))
        else $error("color scale above tonal alpha");

    // The greyscale alpha is clamped to one.
    a_grey_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[4] |-> (grey5_reg <= ONE_V))
        else $error("greyscale alpha above one");
`endif

endmodule : tonal_shadow_color_top

`default_nettype wire

/* hw/rtl/tsc_div.sv */
// Pipelined restoring divider: one quotient bit per register stage.
`default_nettype none

module tsc_div #(
    parameter int FRAC_BITS = tsc_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W    = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 adv,
    input  wire logic                 in_valid,
    input  wire logic [FRAC_BITS:0]   num,
    input  wire logic [FRAC_BITS:0]   den,
    input  wire logic [SIDE_W-1:0]    side_in,
    output logic                      out_valid,
    output logic [FRAC_BITS:0]        quo,
    output logic [FRAC_BITS:0]        den_out,
    output logic [SIDE_W-1:0]         side_out
);
    import tsc_pkg::*;

    localparam int NS = FRAC_BITS + 1;
    localparam int DW = FRAC_BITS + 1;

    logic [DW-1:0]     rem_reg  [NS];
    logic [DW-1:0]     q_reg    [NS];
    logic [DW-1:0]     den_reg  [NS];
    logic [SIDE_W-1:0] side_reg [NS];
    logic [NS-1:0]     vld_reg;

    // Stage j decides quotient bit FRAC_BITS-j. The numerator is num shifted up by
    // FRAC_BITS, so the first stage starts from num and the later ones shift in zeros.
    for (genvar j = 0; j < NS; j++) begin : g_stage
        logic [DW:0]       rem_in;
        logic [DW:0]       diff;
        logic [DW-1:0]     den_in;
        logic [DW-1:0]     q_in;
        logic [SIDE_W-1:0] side_sel;
        logic              ge;
        logic [DW-1:0]     rem_next;
        logic [DW-1:0]     q_next;

        if (j == 0) begin : g_first
            assign rem_in   = {1'b0, num};
            assign den_in   = den;
            assign q_in     = '0;
            assign side_sel = side_in;
        end else begin : g_rest
            assign rem_in   = {rem_reg[j-1], 1'b0};
            assign den_in   = den_reg[j-1];
            assign q_in     = q_reg[j-1];
            assign side_sel = side_reg[j-1];
        end

        // Trial subtraction and quotient bit.
        assign diff     = rem_in - {1'b0, den_in};
        assign ge       = (rem_in >= {1'b0, den_in});
        assign rem_next = ge ? diff[DW-1:0] : rem_in[DW-1:0];

        always_comb begin
            q_next = q_in;
            q_next[FRAC_BITS-j] = ge;
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[j]  <= rem_next;
                q_reg[j]    <= q_next;
                den_reg[j]  <= den_in;
                side_reg[j] <= side_sel;
            end
        end
    end

    // Valid bits move with the data and hold while the pipeline is stalled.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign quo       = q_reg[NS-1];
    assign den_out   = den_reg[NS-1];
    assign side_out  = side_reg[NS-1];

`ifndef SYNTHESIS
    // The final remainder is always below a nonzero divisor.
    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[NS-1] && (den_reg[NS-1] != '0)) |-> (rem_reg[NS-1] < den_reg[NS-1]))
        else $error("divider remainder not below divisor");

    // A stalled pipeline keeps its valid bits.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg))
        else $error("divider valid bits moved during a stall");

    // The numerator never exceeds the divisor, so a quotient of one has no fraction bits.
    a_quo_le_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[NS-1] && (den_reg[NS-1] != '0) && q_reg[NS-1][FRAC_BITS])
        |-> (q_reg[NS-1][FRAC_BITS-1:0] == '0))
        else $error("divider quotient above one");
`endif

endmodule : tsc_div

`default_nettype wire
